### hw/rtl/pdll_pkg.sv
// ----------------------------------------------------------------------------
// pdll_pkg
// Shared types and constants for the Poisson delta log-likelihood block.
// ----------------------------------------------------------------------------
package pdll_pkg;

    localparam int XW            = 32;   // Q16.16 count width
    localparam int NOBS_W        = 16;   // observed count width
    localparam int CHI_W         = 48;   // result width, Q32.16
    localparam int FRAC_BITS_DEF = 16;
    localparam int LOG_FB        = 30;   // fraction bits of the log datapath
    localparam int APB_AW        = 3;

    localparam logic [LOG_FB-1:0] LN2_Q30 = 30'd744261118;

    localparam logic [APB_AW-1:0] REG_MIN_TOTAL = 3'd0;

    localparam logic signed [CHI_W-1:0] CHI_MAX = {1'b0, {(CHI_W-1){1'b1}}};
    localparam logic signed [CHI_W-1:0] CHI_MIN = {1'b1, {(CHI_W-1){1'b0}}};

    typedef struct packed {
        logic [XW-1:0]            expected_count;
        logic [NOBS_W-1:0]        observed_count;
        logic signed [XW-1:0]     background_level;
    } item_t;

    typedef struct packed {
        logic signed [CHI_W-1:0]  delta_chi2;
        logic                     domain_error;
    } result_t;

endpackage

### hw/rtl/poisson_delta_log_likelihood_top.sv
// ----------------------------------------------------------------------------
// poisson_delta_log_likelihood_top
// Poisson likelihood-ratio deviance with a fully pipelined fixed-point log.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while the output is not
// stalled, and returns one result per transaction, in order. The pipeline
// depth comes from the logarithm: each of its 30 fraction bits comes from
// one squaring stage, and three such chains (observed count, expected count
// and bound) run side by side. A stall on the result side freezes the whole
// pipeline and is passed straight back to the input. min_total must be written
// through the APB port at address 0 while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module poisson_delta_log_likelihood_top
    import pdll_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                item_valid,
    output logic                item_stall,
    input  item_t               item,
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result
);

    localparam int RW   = (NOBS_W + FRAC_BITS > XW) ? NOBS_W + FRAC_BITS : XW;
    localparam int KW   = $clog2(RW);
    localparam int SH   = LOG_FB - FRAC_BITS;
    localparam int NSQ  = LOG_FB;
    localparam int MW   = LOG_FB + 1;
    localparam int LNW  = 38;
    localparam int DW   = LNW + 1;
    localparam int PW   = DW + NOBS_W + 1;
    localparam int CW   = 56;
    localparam int BW   = XW + 2;
    localparam int CMPW = RW + 2;

    localparam logic signed [BW-1:0] HALF_NEG = -(BW'(1) <<< (FRAC_BITS - 1));
    localparam logic [PW-1:0]        RND_HALF = PW'(1) << (SH - 1);

    typedef struct packed {
        logic [NOBS_W-1:0]       n;
        logic [XW-1:0]           xb;
        logic [XW-1:0]           xc;
        logic                    use_c;
        logic                    fast;
        logic                    err;
        logic signed [CHI_W-1:0] fast_chi;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [XW-1:0] min_total_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MIN_TOTAL) ? min_total_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_total_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_MIN_TOTAL)
        begin
            min_total_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipe advances unless the output is held.
    // ------------------------------------------------------------------
    logic en;
    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    // ------------------------------------------------------------------
    // Stage 0: bound selection, fast paths and log operands
    // ------------------------------------------------------------------
    logic signed [BW-1:0]   bg_ext;
    logic signed [BW-1:0]   bound_s;
    logic [RW-1:0]          n_raw;
    logic                   use_c;
    logic                   n_zero;
    logic                   x_zero;
    logic signed [CHI_W-1:0] chi_zero_n;
    side_t                  s0_side_next;
    logic [2:0][RW-1:0]     s0_r_next;

    always_comb
    begin
        bg_ext  = BW'(item.background_level);
        bound_s = (bg_ext > HALF_NEG) ? bg_ext : $signed({2'b00, min_total_reg});
        n_raw   = RW'(item.observed_count) << FRAC_BITS;
        n_zero  = (item.observed_count == '0);
        x_zero  = (item.expected_count == '0);
        use_c   = !n_zero && ($signed({2'b00, n_raw}) < CMPW'(bound_s));
        chi_zero_n = $signed(CHI_W'({item.expected_count, 1'b0}));
        if (bound_s > 0)
        begin
            chi_zero_n = chi_zero_n - $signed(CHI_W'({bound_s[BW-2:0], 1'b0}));
        end
        s0_side_next.n        = item.observed_count;
        s0_side_next.xb       = item.expected_count;
        s0_side_next.xc       = bound_s[XW-1:0];
        s0_side_next.use_c    = use_c;
        s0_side_next.fast     = n_zero || x_zero;
        s0_side_next.err      = !n_zero && x_zero;
        s0_side_next.fast_chi = n_zero ? chi_zero_n : CHI_MAX;
        // Unused log lanes get an operand of one so the chain stays defined.
        s0_r_next[0] = n_zero ? RW'(1) : n_raw;
        s0_r_next[1] = x_zero ? RW'(1) : RW'(item.expected_count);
        s0_r_next[2] = use_c ? RW'(bound_s[XW-1:0]) : RW'(1);
    end

    logic               s0_vld_reg;
    side_t              s0_side_reg;
    logic [2:0][RW-1:0] s0_r_reg;

    // ------------------------------------------------------------------
    // Stage 1: position of the leading one
    // ------------------------------------------------------------------
    logic [2:0][KW-1:0] s1_k_next;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            s1_k_next[l] = '0;
            for (int i = 0; i < RW; i++)
            begin
                if (s0_r_reg[l][i])
                begin
                    s1_k_next[l] = KW'(i);
                end
            end
        end
    end

    logic               s1_vld_reg;
    side_t              s1_side_reg;
    logic [2:0][RW-1:0] s1_r_reg;
    logic [2:0][KW-1:0] s1_k_reg;

    // ------------------------------------------------------------------
    // Stage 2 and squaring chain: index 0 holds the normalized mantissa,
    // index j+1 holds it after j+1 squaring steps.
    // ------------------------------------------------------------------
    logic [2:0][MW-1:0]       norm_m;
    logic [RW+LOG_FB-1:0]     norm_wide;

    always_comb
    begin
        norm_wide = '0;
        for (int l = 0; l < 3; l++)
        begin
            norm_wide = {s1_r_reg[l], {LOG_FB{1'b0}}} >> s1_k_reg[l];
            norm_m[l] = norm_wide[MW-1:0];
        end
    end

    logic                    sq_vld_reg  [0:NSQ];
    side_t                   sq_side_reg [0:NSQ];
    logic [2:0][KW-1:0]      sq_k_reg    [0:NSQ];
    logic [2:0][MW-1:0]      sq_m_reg    [0:NSQ];
    logic [2:0][LOG_FB-1:0]  sq_frac_reg [0:NSQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= s1_side_reg;
            sq_k_reg[0]    <= s1_k_reg;
            sq_m_reg[0]    <= norm_m;
            sq_frac_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sq
        logic [2:0][2*MW-1:0]   prod;
        logic [2:0][MW:0]       sqr;
        logic [2:0][MW-1:0]     m_next;
        logic [2:0][LOG_FB-1:0] frac_next;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                prod[l] = (2*MW)'(sq_m_reg[j][l]) * (2*MW)'(sq_m_reg[j][l]);
                sqr[l]  = prod[l][2*MW-1:LOG_FB];
                // A square at or above two yields a one bit and is halved.
                m_next[l]    = sqr[l][MW] ? sqr[l][MW:1] : sqr[l][MW-1:0];
                frac_next[l] = {sq_frac_reg[j][l][LOG_FB-2:0], sqr[l][MW]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_side_reg[j+1] <= sq_side_reg[j];
                sq_k_reg[j+1]    <= sq_k_reg[j];
                sq_m_reg[j+1]    <= m_next;
                sq_frac_reg[j+1] <= frac_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Log assembly: ln = k*ln2 + round(frac*ln2)
    // ------------------------------------------------------------------
    logic [2:0][LNW-1:0]      ln_next;
    logic [2:0][2*LOG_FB-1:0] frac_ln;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            frac_ln[l] = (2*LOG_FB)'(sq_frac_reg[NSQ][l]) * (2*LOG_FB)'(LN2_Q30)
                         + ((2*LOG_FB)'(1) << (LOG_FB - 1));
            ln_next[l] = LNW'(sq_k_reg[NSQ][l]) * LNW'(LN2_Q30)
                         + LNW'(frac_ln[l][2*LOG_FB-1:LOG_FB]);
        end
    end

    logic                 ln_vld_reg;
    side_t                ln_side_reg;
    logic [2:0][LNW-1:0]  ln_reg;

    // ------------------------------------------------------------------
    // Log differences, products with n, rounding and the deviance terms
    // ------------------------------------------------------------------
    logic signed [DW-1:0] d1_next, d2_next;

    assign d1_next = $signed({1'b0, ln_reg[0]}) - $signed({1'b0, ln_reg[1]});
    assign d2_next = $signed({1'b0, ln_reg[0]}) - $signed({1'b0, ln_reg[2]});

    logic                 d_vld_reg;
    side_t                d_side_reg;
    logic signed [DW-1:0] d1_reg, d2_reg;

    logic signed [PW-1:0] p1_next, p2_next;

    assign p1_next = $signed(PW'(d_side_reg.n)) * PW'(d1_reg);
    assign p2_next = $signed(PW'(d_side_reg.n)) * PW'(d2_reg);

    logic                 p_vld_reg;
    side_t                p_side_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;

    function automatic logic signed [CW-1:0] dev_term(
        input logic [XW-1:0]        x,
        input logic [NOBS_W-1:0]    n,
        input logic signed [PW-1:0] p
    );
        logic [PW-1:0]        mag;
        logic [PW-1:0]        qm;
        logic signed [CW-1:0] q;
        logic signed [CW-1:0] nr;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        qm  = (mag + RND_HALF) >> SH;
        q   = p[PW-1] ? -$signed(CW'(qm)) : $signed(CW'(qm));
        nr  = $signed(CW'(n) << FRAC_BITS);
        return ($signed(CW'(x)) - nr + q) <<< 1;
    endfunction

    logic signed [CW-1:0] t1_next, t2_next;

    assign t1_next = dev_term(p_side_reg.xb, p_side_reg.n, p1_reg);
    assign t2_next = dev_term(p_side_reg.xc, p_side_reg.n, p2_reg);

    logic                 t_vld_reg;
    side_t                t_side_reg;
    logic signed [CW-1:0] t1_reg, t2_reg;

    // ------------------------------------------------------------------
    // Final combine and saturation
    // ------------------------------------------------------------------
    logic signed [CW-1:0] chi;
    result_t              result_next;

    always_comb
    begin
        if (t_side_reg.fast)
        begin
            chi = CW'(t_side_reg.fast_chi);
        end
        else if (t_side_reg.use_c)
        begin
            chi = t1_reg - t2_reg;
        end
        else
        begin
            chi = t1_reg;
        end
        if (chi > CW'(CHI_MAX))
        begin
            result_next.delta_chi2 = CHI_MAX;
        end
        else if (chi < CW'(CHI_MIN))
        begin
            result_next.delta_chi2 = CHI_MIN;
        end
        else
        begin
            result_next.delta_chi2 = chi[CHI_W-1:0];
        end
        result_next.domain_error = t_side_reg.err;
    end

    logic    out_vld_reg;
    result_t out_reg;

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // Stage registers outside the squaring chain
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            ln_vld_reg  <= 1'b0;
            d_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            t_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg  <= item_valid;
            s1_vld_reg  <= s0_vld_reg;
            ln_vld_reg  <= sq_vld_reg[NSQ];
            d_vld_reg   <= ln_vld_reg;
            p_vld_reg   <= d_vld_reg;
            t_vld_reg   <= p_vld_reg;
            out_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side_reg <= s0_side_next;
            s0_r_reg    <= s0_r_next;
            s1_side_reg <= s0_side_reg;
            s1_r_reg    <= s0_r_reg;
            s1_k_reg    <= s1_k_next;
            ln_side_reg <= sq_side_reg[NSQ];
            ln_reg      <= ln_next;
            d_side_reg  <= ln_side_reg;
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            p_side_reg  <= d_side_reg;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            t_side_reg  <= p_side_reg;
            t1_reg      <= t1_next;
            t2_reg      <= t2_next;
            out_reg     <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.domain_error |-> result.delta_chi2 == CHI_MAX)
        else $error("domain error without saturated result");

    a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("input stall does not follow the held output");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        t_vld_reg && en |=> result_valid)
        else $error("finished transaction did not reach the output");

endmodule

### tb/tb_poisson_delta_log_likelihood_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for poisson_delta_log_likelihood_top
// Drives count triples through the valid/stall input, predicts the deviance
// in fixed point, and compares every result in order. min_total is changed
// over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_poisson_delta_log_likelihood_top
    import pdll_pkg::*;
();

    localparam int FB = FRAC_BITS_DEF;
    localparam longint CHI_HI = 64'sd140737488355327;
    localparam longint CHI_LO = -64'sd140737488355328;

    class deviance_scoreboard;
        result_t pending[$];
        logic [31:0] min_total;
        int errors;
        int checked;

        function new();
            min_total = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint unsigned ln_q30(longint unsigned r);
            int k;
            longint unsigned m;
            longint unsigned frac;
            k = 0;
            frac = 0;
            for (int i = 0; i < 64; i++)
                if (r[i])
                    k = i;
            if (k > 30)
                m = r >> (k - 30);
            else
                m = r << (30 - k);
            for (int i = 0; i < 30; i++)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30))
                begin
                    m = m >> 1;
                    frac[29 - i] = 1'b1;
                end
            end
            return longint'(k) * 744261118 + ((frac * 744261118 + (64'd1 << 29)) >> 30);
        endfunction

        function longint deviance_term(longint unsigned x, longint unsigned n);
            longint unsigned nr;
            longint d;
            longint p;
            longint q;
            longint unsigned half;
            nr = n << FB;
            d = longint'(ln_q30(nr)) - longint'(ln_q30(x));
            p = longint'(n) * d;
            half = 64'd1 << (30 - FB - 1);
            if (p >= 0)
                q = longint'((unsigned'(p) + half) >> (30 - FB));
            else
                q = -longint'((unsigned'(-p) + half) >> (30 - FB));
            return 2 * (longint'(x) - longint'(nr) + q);
        endfunction

        function void note_item(item_t it);
            longint nexp;
            longint n;
            longint b;
            longint bound;
            longint chi;
            result_t r;
            nexp = longint'({32'd0, it.expected_count});
            n = longint'({48'd0, it.observed_count});
            b = longint'(it.background_level);
            bound = (b > -(64'sd1 << (FB - 1))) ? b : longint'({32'd0, min_total});
            r.domain_error = 1'b0;
            if (n == 0)
            begin
                chi = 2 * nexp;
                if (bound > 0)
                    chi -= 2 * bound;
            end
            else if (nexp == 0)
            begin
                r.domain_error = 1'b1;
                chi = CHI_HI;
            end
            else
            begin
                chi = deviance_term(nexp, n);
                if ((n << FB) < bound)
                    chi -= deviance_term(bound, n);
            end
            if (chi > CHI_HI)
                chi = CHI_HI;
            if (chi < CHI_LO)
                chi = CHI_LO;
            r.delta_chi2 = chi[CHI_W-1:0];
            pending.push_back(r);
        endfunction

        task check_result(result_t got);
            result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no transaction outstanding", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.delta_chi2 !== want.delta_chi2)
                report_mismatch("delta_chi2", got.delta_chi2, want.delta_chi2);
            if (got.domain_error !== want.domain_error)
                report_mismatch("domain_error", got.domain_error, want.domain_error);
        endtask

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("MISMATCH %s at result %0d: got %0h expected %0h",
                     what, checked, got, want);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic item_valid, item_stall;
    item_t item;
    logic result_valid, result_stall;
    result_t result;

    deviance_scoreboard sb;
    bit quiet;      // no idling on either side
    int sent;

    poisson_delta_log_likelihood_top uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Input acceptance and result checking happen on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(item);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // Receiver stall in random bursts.
    initial
    begin
        int len;
        result_stall = 0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 8);
                result_stall = 1;
                repeat (len) @(negedge clk);
                result_stall = 0;
            end
        end
    end

    task automatic write_min_total(logic [31:0] value);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1; paddr = REG_MIN_TOTAL; pwdata = value;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.min_total = value;
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic send_item(item_t it);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            item_valid = 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        item = it;
        item_valid = 1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        item_valid = 0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic item_t make(logic [31:0] e, logic [15:0] n, logic [31:0] b);
        item_t it;
        it.expected_count = e;
        it.observed_count = n;
        it.background_level = b;
        return it;
    endfunction

    function automatic item_t random_item();
        logic [31:0] e;
        logic [15:0] n;
        logic [31:0] b;
        n = 16'($urandom_range(0, 40));
        case ($urandom_range(0, 4))
            0: n = 16'($urandom);
            1: n = 0;
            default: ;
        endcase
        e = $urandom_range(1, 64) << $urandom_range(8, 18);
        if ($urandom_range(0, 9) == 0)
            e = $urandom;
        if ($urandom_range(0, 19) == 0)
            e = 0;
        case ($urandom_range(0, 3))
            0: b = $urandom;
            1: b = -$urandom_range(0, 200000);
            default: b = $urandom_range(0, 64) << $urandom_range(10, 18);
        endcase
        return make(e, n, b);
    endfunction

    initial
    begin
        logic [31:0] settings[5];
        sb = new();
        quiet = 0;
        sent = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        item_valid = 0;
        item = '0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: field extremes, zero observed, zero expected, bound cases.
        send_item(make(32'h0, 16'h0, 32'h0));
        send_item(make(32'hFFFF_FFFF, 16'h0, 32'h7FFF_FFFF));
        send_item(make(32'hFFFF_FFFF, 16'h0, 32'h8000_0000));
        send_item(make(32'h0, 16'h0, 32'h7FFF_FFFF));
        send_item(make(32'h0, 16'd5, 32'h0001_0000));
        send_item(make(32'h0, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make(32'h0001_0000, 16'd1, 32'h0001_0000));
        send_item(make(32'h0000_0001, 16'hFFFF, 32'h8000_0000));
        send_item(make(32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF));
        send_item(make(32'hFFFF_FFFF, 16'd1, 32'h7FFF_FFFF));
        send_item(make(32'h0003_0000, 16'd2, 32'h000A_0000));
        send_item(make(32'h0003_0000, 16'd2, 32'hFFFF_8000));
        send_item(make(32'h0003_0000, 16'd2, 32'hFFFF_8001));
        send_item(make(32'h0003_0000, 16'd0, 32'hFFFF_8001));
        send_item(make(32'h0000_8000, 16'd3, 32'h0003_0000));
        drain();

        settings[0] = 32'hFFFF_FFFF;
        settings[1] = 32'h0000_0001;
        settings[2] = 32'h0010_0000;
        settings[3] = 32'h0000_0000;
        settings[4] = 32'h0400_0000;
        for (int p = 0; p < 5; p++)
        begin
            write_min_total(settings[p]);
            send_item(make(32'h0002_0000, 16'd1, 32'h8000_0000));
            send_item(make(32'h0002_0000, 16'd0, 32'hFFFF_0000));
            send_item(make(32'h0, 16'd3, 32'hFFFF_0000));
            for (int i = 0; i < 115; i++)
            begin
                if (p == 4 && i == 60)
                    quiet = 1;
                if (i == 50)
                    drain();
                send_item(random_item());
            end
            drain();
        end

        $display("Sent %0d transactions over five min_total settings; %0d results checked.",
                 sent, sb.checked);
        $display("Covered zero counts, domain errors, bound selection and saturation.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
